@@ hw/rtl/tbr_pkg.sv @@
// ----------------------------------------------------------------------------
// tbr_pkg: shared types and constants of the token bucket reserve unit
// Field widths, saturation limits and register indexes of the config port.
// ----------------------------------------------------------------------------
`default_nettype none

package tbr_pkg;

	localparam int CNT_W    = 16;
	localparam int BURST_W  = 16;
	localparam int WAIT_W   = 40;
	localparam int BAL_W    = 41;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 1;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_INTERVAL = 1'b0;
	localparam reg_idx_t REG_BURST    = 1'b1;

	localparam logic [BURST_W-1:0] BURST_RESET = 16'd1;

	localparam logic signed [BAL_W-1:0] BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
	localparam logic signed [BAL_W-1:0] BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};
	localparam logic [WAIT_W-1:0]       WAIT_MAX = {WAIT_W{1'b1}};

endpackage

`default_nettype wire

@@ hw/rtl/token_bucket_reserve_unit.sv @@
// ----------------------------------------------------------------------------
// token_bucket_reserve_unit: token bucket rate limiter with reservations
// Refills one scaled unit per elapsed microsecond up to burst times interval,
// grants requests up to burst and reports the wait and the scaled balance.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------
//  request   req_valid / req_ready  now_time, request_count
//  response  rsp_valid / rsp_ready  granted, wait_us, balance_scaled
//  config    apb psel/penable       paddr, pwdata, prdata (pready tied high)
//
//  one transaction per cycle while the response is not stalled; a request
//  is registered in stage 1 and then in stage 2, whose valid is rsp_valid
//  (stage 1 holds the count times interval product, stage 2
//  the refill, subtract and saturate against the bucket state)
//  the capacity product burst times interval is registered in cap_q from
//  the burst and interval registers after a config write
//  reset clears the bucket level and the last grant time, interval 0, burst 1
//  a stalled response holds stage 2 and stage 1; req_ready falls only when
//  both are full and rsp_ready is low
//
`default_nettype none

module token_bucket_reserve_unit #(
	parameter int TIME_BITS     = 48,
	parameter int INTERVAL_BITS = 24
) (
	input  wire                               clk,
	input  wire                               arst_n,

	input  wire                               req_valid,
	output logic                              req_ready,
	input  wire  [TIME_BITS-1:0]              now_time,
	input  wire  [tbr_pkg::CNT_W-1:0]         request_count,

	output logic                              rsp_valid,
	input  wire                               rsp_ready,
	output logic                              granted,
	output logic [tbr_pkg::WAIT_W-1:0]        wait_us,
	output logic signed [tbr_pkg::BAL_W-1:0]  balance_scaled,

	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [tbr_pkg::PADDR_W-1:0]       paddr,
	input  wire  [tbr_pkg::PDATA_W-1:0]       pwdata,
	output logic [tbr_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	import tbr_pkg::*;

	localparam int PROD_W = CNT_W + INTERVAL_BITS;
	localparam int CAP_W  = BURST_W + INTERVAL_BITS;
	localparam int CW     = CAP_W + BAL_W;
	localparam int GW     = BAL_W + 1;
	localparam int EW     = (TIME_BITS > GW) ? TIME_BITS : GW;
	localparam int DW     = ((PROD_W > GW) ? PROD_W : GW) + 2;

	// configuration
	logic [INTERVAL_BITS-1:0]  interval_q;
	logic [BURST_W-1:0]        burst_q;
	logic signed [BAL_W-1:0]   cap_q;
	logic [CAP_W-1:0]          cap_full;
	logic                      cfg_wr;
	reg_idx_t                  reg_idx;

	// bucket state
	logic signed [BAL_W-1:0]   level_q;
	logic [TIME_BITS-1:0]      last_time_q;

	// stage 1
	logic                      valid_s1;
	logic [TIME_BITS-1:0]      now_s1;
	logic [CNT_W-1:0]          cnt_s1;
	logic [PROD_W-1:0]         prod_s1;
	logic                      fits_s1;
	logic                      unlim_s1;

	// stage 2 (response register)
	logic                      valid_s2;
	logic                      granted_s2;
	logic [WAIT_W-1:0]         wait_s2;
	logic signed [BAL_W-1:0]   bal_s2;

	logic                      adv_s2;
	logic                      adv_s1;
	logic                      take_grant;

	logic [TIME_BITS-1:0]      elapsed;
	logic [EW-1:0]             elapsed_ext;
	logic signed [GW-1:0]      gap;
	logic signed [GW-1:0]      level_ref;
	logic signed [DW-1:0]      diff;
	logic signed [BAL_W-1:0]   bal_sat;
	logic signed [GW-1:0]      deficit;
	logic [WAIT_W-1:0]         wait_calc;
	logic                      grant_calc;
	logic signed [BAL_W-1:0]   bal_out;

	// ---------------------------------------------------------------- config
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= '0;
			burst_q    <= BURST_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_INTERVAL: interval_q <= pwdata[INTERVAL_BITS-1:0];
				REG_BURST:    burst_q    <= pwdata[BURST_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_INTERVAL: prdata = PDATA_W'(interval_q);
			REG_BURST:    prdata = PDATA_W'(burst_q);
		endcase
	end

	// capacity in scaled units, saturated to the balance range
	assign cap_full = CAP_W'(burst_q) * CAP_W'(interval_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (CW'(cap_full) > CW'(unsigned'(BAL_MAX))) begin
			cap_q <= BAL_MAX;
		end else begin
			cap_q <= signed'(BAL_W'(cap_full));
		end
	end

	// ---------------------------------------------------------------- flow
	assign adv_s2     = valid_s1 && (!valid_s2 || rsp_ready);
	assign adv_s1     = req_valid && req_ready;
	assign req_ready  = !valid_s1 || adv_s2;
	assign take_grant = adv_s2 && !unlim_s1 && fits_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			now_s1   <= now_time;
			cnt_s1   <= request_count;
			prod_s1  <= PROD_W'(request_count) * PROD_W'(interval_q);
			fits_s1  <= request_count <= burst_q;
			unlim_s1 <= interval_q == '0;
		end
	end

	// ---------------------------------------------------------------- refill
	assign elapsed     = (now_s1 > last_time_q) ? now_s1 - last_time_q : '0;
	assign elapsed_ext = EW'(elapsed);
	assign gap         = GW'(cap_q) - GW'(level_q);

	always_comb begin
		if (level_q >= cap_q) begin
			level_ref = GW'(cap_q);
		end else if (elapsed_ext >= EW'(unsigned'(gap))) begin
			level_ref = GW'(cap_q);
		end else begin
			// below the gap, so the elapsed time fits the positive range
			level_ref = GW'(level_q) + signed'({1'b0, elapsed_ext[GW-2:0]});
		end
	end

	assign diff = DW'(level_ref) - signed'(DW'(prod_s1));

	always_comb begin
		if (diff > DW'(BAL_MAX)) begin
			bal_sat = BAL_MAX;
		end else if (diff < DW'(BAL_MIN)) begin
			bal_sat = BAL_MIN;
		end else begin
			bal_sat = diff[BAL_W-1:0];
		end
	end

	assign deficit = -GW'(bal_sat);

	always_comb begin
		wait_calc = '0;
		if (fits_s1 && bal_sat < 0) begin
			if (GW'(unsigned'(deficit)) > GW'(WAIT_MAX)) begin
				wait_calc = WAIT_MAX;
			end else begin
				wait_calc = deficit[WAIT_W-1:0];
			end
		end
	end

	// unlimited rate passes the count through untouched
	assign grant_calc = unlim_s1 || fits_s1;
	assign bal_out    = unlim_s1 ? signed'(BAL_W'(cnt_s1)) : bal_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			last_time_q <= '0;
		end else if (take_grant) begin
			level_q     <= bal_sat;
			last_time_q <= now_s1;
		end
	end

	// ---------------------------------------------------------------- response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			granted_s2 <= grant_calc;
			wait_s2    <= unlim_s1 ? '0 : wait_calc;
			bal_s2     <= bal_out;
		end
	end

	assign rsp_valid      = valid_s2;
	assign granted        = granted_s2;
	assign wait_us        = wait_s2;
	assign balance_scaled = bal_s2;

	// ---------------------------------------------------------------- checks
	a_refused_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !granted_s2 |-> wait_s2 == '0)
		else $error("refused transaction reports a wait");

	a_wait_needs_deficit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && wait_s2 != '0 |-> bal_s2 < 0)
		else $error("wait reported without a negative balance");

	a_state_only_on_grant: assert property (@(posedge clk) disable iff (!arst_n)
		!take_grant |=> $stable(last_time_q) && $stable(level_q))
		else $error("bucket state changed without a grant");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s1)
		else $error("accepted transaction lost before stage 1");

endmodule

`default_nettype wire
